// ----- rtl/core/stream_duplicate_filter_unit_defines.svh -----
// Assertion macros shared by the stream duplicate filter RTL.
`ifndef STREAM_DUPLICATE_FILTER_UNIT_DEFINES_SVH
`define STREAM_DUPLICATE_FILTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SDF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDF_ASSERT(lbl, prop, msg)
`define SDF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/sdf_pkg.sv -----
// Package with the constants and token type of the stream duplicate filter.
package sdf_pkg;

	localparam int STORE_DEPTH = 64;

	typedef logic signed [31:0] value_t;

	// Request moving down the cell chain
	typedef struct packed {
		logic   valid;
		value_t value;
		logic   clr;
		logic   matched;
		logic   stored;
	} token_t;

endpackage

// ----- rtl/core/sdf_cell.sv -----
// One cell of the filter chain: holds one stored value and passes requests on.
module sdf_cell
	import sdf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  token_t tok_in,
	output token_t tok_out
);

	logic   occupied_q;
	value_t entry_q;
	logic   valid_q;
	value_t value_q;
	logic   clr_q;
	logic   matched_q;
	logic   stored_q;

	logic occ_eff;
	logic pending;
	logic hit;
	logic capture;

	// Empty the cell ahead of the compare when a new set passes
	assign occ_eff = occupied_q && !(tok_in.valid && tok_in.clr);
	assign pending = tok_in.valid && !tok_in.matched && !tok_in.stored;
	assign hit     = pending && occ_eff && (entry_q == tok_in.value);
	assign capture = pending && !occ_eff;

	// Update the cell and advance the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
			valid_q    <= 1'b0;
		end else if (advance) begin
			occupied_q <= occ_eff || capture;
			valid_q    <= tok_in.valid;
		end
	end

	// Payload registers carry no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			if (capture) begin
				entry_q <= tok_in.value;
			end
			value_q   <= tok_in.value;
			clr_q     <= tok_in.clr;
			matched_q <= tok_in.matched || hit;
			stored_q  <= tok_in.stored || capture;
		end
	end

	assign tok_out = '{
		valid:   valid_q,
		value:   value_q,
		clr:     clr_q,
		matched: matched_q,
		stored:  stored_q
	};

endmodule

// ----- rtl/core/sdf_out_stage.sv -----
// Output register of the filter: turns finished requests into results.
module sdf_out_stage
	import sdf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  token_t tok_in,
	output logic   advance,
	output logic   out_valid,
	input  logic   out_ready,
	output value_t unique_value,
	output logic   store_full
);

	logic   valid_q;
	value_t value_q;
	logic   full_q;
	logic   emit;

	// Advance the chain whenever the result register is free or being drained
	assign advance = !valid_q || out_ready;
	assign emit    = tok_in.valid && !tok_in.matched;

	// Hold or load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q <= tok_in.value;
			full_q  <= !tok_in.stored;
		end
	end

	assign out_valid    = valid_q;
	assign unique_value = value_q;
	assign store_full   = full_q;

endmodule

// ----- rtl/core/stream_duplicate_filter_unit.sv -----
// Stream duplicate filter: passes on the first occurrence of each value in a set.
// A request enters a chain of STORE_DEPTH cells, each holding one stored value,
// and moves one cell per cycle while the chain advances; a new request is
// accepted every cycle unless the result register is stalled. On leaving the
// last cell an unmatched request is loaded into the result register, which
// holds it until it is taken. A new value is written into the first free cell
// it meets; a start of set empties each cell as it passes, so requests behind
// it see an empty store. A value that finds no match and no free cell leaves
// with store_full set.
`include "stream_duplicate_filter_unit_defines.svh"

module stream_duplicate_filter_unit
	import sdf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  value_t sample_value,
	input  logic   start_of_set,
	output logic   out_valid,
	input  logic   out_ready,
	output value_t unique_value,
	output logic   store_full
);

	token_t tok [0:STORE_DEPTH];
	logic   advance;
	token_t tail;
	logic   tail_hit;
	logic   tail_miss;

	// Build the request from the input ports
	always_comb begin
		tok[0].valid   = in_valid;
		tok[0].value   = sample_value;
		tok[0].clr     = start_of_set;
		tok[0].matched = 1'b0;
		tok[0].stored  = 1'b0;
	end

	assign in_ready = advance;

	// Chain of store cells
	for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
		sdf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	sdf_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_in       (tok[STORE_DEPTH]),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.unique_value (unique_value),
		.store_full   (store_full)
	);

	// Classify the request leaving the chain
	assign tail      = tok[STORE_DEPTH];
	assign tail_hit  = tail.valid && tail.matched;
	assign tail_miss = tail.valid && !tail.matched && !tail.stored;

	// A request is never both matched and stored
	`SDF_ASSERT(a_match_xor_store, !(tail_hit && tail.stored), "request matched and stored")
	// A stalled chain holds its last request
	`SDF_ASSERT(a_stall_holds, (!advance && tail.valid) |=> $stable(tail), "chain moved in stall")
	// An unmatched request that found no free cell leaves flagged full
	`SDF_ASSERT(a_full_result, (advance && tail_miss) |=> (out_valid && store_full), "no full flag")
	// A matched request produces no result
	`SDF_ASSERT(a_dup_dropped, (advance && tail_hit) |=> !out_valid, "duplicate emitted")

endmodule

// ----- verif/tb.sv -----
// Testbench for the stream duplicate filter: random sets against a first-occurrence predictor.
`timescale 1ns / 100ps

module tb;
	import sdf_pkg::*;

	localparam int RANDOM_REQUESTS = 1450;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = STORE_DEPTH + 16;

	typedef struct {
		value_t value;
		logic   full;
	} unique_result_t;

	// Predict first occurrences and check results in order
	class dedup_scoreboard;
		value_t         seen_values[STORE_DEPTH];
		int unsigned    seen_count;
		unique_result_t expected_uniques[$];
		int unsigned    errors;
		int unsigned    results_checked;
		int unsigned    full_results;
		int unsigned    repeats_dropped;

		function new();
			seen_count      = 0;
			errors          = 0;
			results_checked = 0;
			full_results    = 0;
			repeats_dropped = 0;
		endfunction

		function void note_request(value_t v, logic sos);
			unique_result_t r;
			bit             hit;
			if (sos)
				seen_count = 0;
			hit = 1'b0;
			for (int i = 0; i < seen_count; i++)
				if (seen_values[i] == v)
					hit = 1'b1;
			if (hit) begin
				repeats_dropped++;
				return;
			end
			r.value = v;
			r.full  = (seen_count >= STORE_DEPTH);
			if (!r.full) begin
				seen_values[seen_count] = v;
				seen_count++;
			end
			expected_uniques.push_back(r);
		endfunction

		task report(string what);
			$display("%0t ERROR: %s", $time, what);
			errors++;
		endtask

		task check_result(value_t v, logic full);
			unique_result_t r;
			if (expected_uniques.size() == 0) begin
				report($sformatf("unexpected result unique_value=%0d store_full=%0b", v, full));
				return;
			end
			r = expected_uniques.pop_front();
			results_checked++;
			if (r.full)
				full_results++;
			if (v !== r.value)
				report($sformatf("unique_value %0d, expected %0d", v, r.value));
			if (full !== r.full)
				report($sformatf("store_full %0b, expected %0b (value %0d)", full, r.full, r.value));
		endtask

		function int pending();
			return expected_uniques.size();
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	value_t sample_value;
	logic   start_of_set;
	logic   out_valid;
	logic   out_ready;
	value_t unique_value;
	logic   store_full;

	dedup_scoreboard sb;
	int unsigned     requests_sent;
	int unsigned     sets_started;
	int unsigned     burst_left;
	int unsigned     stall_cycles;

	stream_duplicate_filter_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.start_of_set(start_of_set),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.unique_value(unique_value),
		.store_full  (store_full)
	);

	always #1 clk = ~clk;

	// Offer one request, idling between bursts, and hold it until accepted
	task automatic send_request(input value_t v, input logic sos);
		int unsigned gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6:    gap = $urandom_range(1, 3);
				7, 8:       gap = $urandom_range(4, 12);
				default:    gap = $urandom_range(13, 24);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
			                                         : $urandom_range(1, 40);
		end
		burst_left--;
		in_valid     <= 1'b1;
		sample_value <= v;
		start_of_set <= sos;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(v, sos);
		requests_sent++;
		if (sos)
			sets_started++;
	endtask

	// Set of values drawn from a narrow pool, so repeats are common
	task automatic send_pooled_set();
		value_t      base;
		int unsigned span;
		int unsigned len;
		logic        sos;
		base = value_t'($urandom);
		span = $urandom_range(2, 31);
		len  = $urandom_range(1, 40);
		for (int i = 0; i < len; i++) begin
			sos = (i == 0);
			send_request(base + value_t'($urandom_range(0, span)), sos);
		end
	endtask

	// Set that overflows the store, then replays stored and unstored values
	task automatic send_overflow_set();
		value_t      fresh[$];
		int unsigned len;
		len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 16);
		for (int i = 0; i < len; i++)
			fresh.push_back(value_t'($urandom));
		for (int i = 0; i < len; i++)
			send_request(fresh[i], i == 0);
		for (int i = 0; i < 16; i++)
			send_request(fresh[$urandom_range(0, len - 1)], 1'b0);
	endtask

	// Noise: fully random values with stray set starts
	task automatic send_noise();
		int unsigned len;
		len = $urandom_range(1, 20);
		for (int i = 0; i < len; i++)
			send_request(value_t'($urandom), $urandom_range(0, 15) == 0);
	endtask

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(unique_value, store_full);
	end

	// Stop the run when no request moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("** stream_duplicate_filter_unit: FAILED **");
				$finish;
			end
		end
	end

	// Stall the output side: free run, one long hold-off, then mixed patterns
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		repeat (100) @(posedge clk);
		out_ready <= 1'b0;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		forever begin
			case ($urandom_range(0, 3))
				0: begin
					out_ready <= 1'b1;
					repeat ($urandom_range(50, 200)) @(posedge clk);
				end
				1: begin
					repeat ($urandom_range(50, 200)) begin
						out_ready <= ($urandom_range(0, 9) >= 3);
						@(posedge clk);
					end
				end
				2: begin
					for (int i = 0; i < 150; i++) begin
						out_ready <= ((i % 5) < 2);
						@(posedge clk);
					end
				end
				default: begin
					out_ready <= 1'b0;
					repeat ($urandom_range(5, 60)) @(posedge clk);
				end
			endcase
		end
	end

	// Reset, directed requests, random sets, drain
	initial begin
		sb            = new();
		requests_sent = 0;
		sets_started  = 0;
		burst_left    = 0;
		stall_cycles  = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		sample_value <= '0;
		start_of_set <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, bit patterns, repeats, and a set start on a repeated value
		send_request(32'sh8000_0000, 1'b1);
		send_request(32'sh7FFF_FFFF, 1'b0);
		send_request(32'sh0000_0000, 1'b0);
		send_request(-32'sd1, 1'b0);
		send_request(32'sh8000_0000, 1'b0);
		send_request(32'sh0000_0000, 1'b0);
		send_request(32'sh5555_5555, 1'b0);
		send_request(32'shAAAA_AAAA, 1'b0);
		send_request(32'sh5555_5555, 1'b0);
		send_request(32'sh0000_0000, 1'b1);
		send_request(32'sh0000_0000, 1'b0);
		send_request(32'sh7FFF_FFFF, 1'b0);
		send_request(32'sh7FFF_FFFF, 1'b1);
		send_request(32'sh0000_0001, 1'b0);
		send_request(-32'sd1, 1'b0);
		send_request(-32'sd1, 1'b0);

		// Random sets, mostly well formed
		send_overflow_set();
		while (requests_sent < RANDOM_REQUESTS + 16) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_pooled_set();
				6, 7:             send_overflow_set();
				default:          send_noise();
			endcase
		end
		in_valid <= 1'b0;

		// Drain, then allow for requests that leave no result
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("Covered %0d requests in %0d sets: %0d results checked, %0d with store full,",
			requests_sent, sets_started, sb.results_checked, sb.full_results);
		$display("%0d repeats dropped, %0d mismatches.", sb.repeats_dropped, sb.errors);
		if (sb.errors == 0)
			$display("** stream_duplicate_filter_unit: PASSED **");
		else
			$display("** stream_duplicate_filter_unit: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sdf_pkg.sv
rtl/core/sdf_cell.sv
rtl/core/sdf_out_stage.sv
rtl/core/stream_duplicate_filter_unit.sv
verif/tb.sv
